// ----- src/rwtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rwtc_pkg
// Shared types and constants of the wall texture column mapper.
// ----------------------------------------------------------------------------
package rwtc_pkg;

	localparam int TEX_BITS  = 6;
	localparam int TEX_DIM   = 1 << TEX_BITS;
	localparam int TEX_AREA  = TEX_DIM * TEX_DIM;
	localparam int LOC_W     = 2 * TEX_BITS;
	localparam int ADDR_W    = LOC_W + 2;
	localparam int STEP_W    = TEX_BITS + 17;
	localparam int POS_W     = 40;
	localparam int OFF_W     = 16;
	localparam int LH_W      = 15;
	localparam int SH_W      = 13;

	localparam logic [SH_W-1:0] SH_RESET = SH_W'(480);

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_COLUMN = 2'd1;
	localparam logic [1:0] KIND_ROW    = 2'd2;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_EAST  = 2'd2;
	localparam logic [1:0] FACE_WEST  = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         tex_id;
		logic [11:0]        texel_addr;
		logic signed [31:0] texel_value;
		logic               side;
		logic               dir_x_neg;
		logic               dir_y_pos;
		logic [15:0]        wall_x;
		logic [14:0]        line_height;
		logic [11:0]        first_row;
		logic [12:0]        stop_row;
		logic [11:0]        column;
	} cmd_t;

	typedef struct packed {
		logic [11:0]        row;
		logic [11:0]        pixel_column;
		logic signed [31:0] color;
		logic               write;
		logic               last;
	} pix_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- src/rwtc_div.sv -----
// ----------------------------------------------------------------------------
// rwtc_div
// Restoring divider, one quotient bit per cycle: TEX_DIM * 65536 / divisor.
// ----------------------------------------------------------------------------
module rwtc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rwtc_pkg::LH_W-1:0]       divisor,
	output rwtc_pkg::div_stat_t             stat,
	output logic [rwtc_pkg::STEP_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(rwtc_pkg::STEP_W);

	logic [CNT_W-1:0]              cnt_q;
	logic [rwtc_pkg::LH_W-1:0]     div_q;
	logic [rwtc_pkg::LH_W-1:0]     rem_q;
	logic [rwtc_pkg::STEP_W-1:0]   quo_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          dbit;
	logic [rwtc_pkg::LH_W:0]       rem_sh;
	logic [rwtc_pkg::LH_W:0]       rem_sub;
	logic                          qbit;

	// dividend is a single set bit at its top position
	assign dbit    = (cnt_q == CNT_W'(rwtc_pkg::STEP_W - 1));
	assign rem_sh  = {rem_q, dbit};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign qbit    = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(rwtc_pkg::STEP_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= (divisor == '0) ? rwtc_pkg::LH_W'(1) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[rwtc_pkg::LH_W-1:0] : rem_sh[rwtc_pkg::LH_W-1:0];
			quo_q <= {quo_q[rwtc_pkg::STEP_W-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- src/raycast_wall_texture_column_top.sv -----
// ----------------------------------------------------------------------------
// raycast_wall_texture_column_top
// Textures one screen column of a grid raycaster from four wall textures.
// ----------------------------------------------------------------------------
// Load and row words are taken one per cycle while no column is in setup and
// the output is not stalled; a row word reads the texture RAM into a register,
// and its pixel moves on to the output register once that is free. A column
// word holds the input through the bit-serial step divide (ST_DIV) and then
// the start-position multiply (ST_MUL). Texture memory is not cleared after
// reset; every texel that a column reads must have been loaded first.
module raycast_wall_texture_column_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rwtc_pkg::SH_W-1:0]     cfg_wdata,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  rwtc_pkg::cmd_t                cmd,
	output logic                          pix_valid,
	input  logic                          pix_ready,
	output rwtc_pkg::pix_t                pix
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL} state_t;

	localparam int MEM_DEPTH = 4 * rwtc_pkg::TEX_AREA;

	state_t                              state_q;
	logic [rwtc_pkg::SH_W-1:0]           sh_q;
	logic [1:0]                          face_q;
	logic [rwtc_pkg::TEX_BITS-1:0]       tex_col_q;
	logic [rwtc_pkg::STEP_W-1:0]         step_q;
	logic signed [rwtc_pkg::POS_W-1:0]   pos_q;
	logic [12:0]                         cur_row_q;
	logic [12:0]                         end_row_q;
	logic [11:0]                         col_q;
	logic signed [rwtc_pkg::OFF_W-1:0]   offset_q;

	logic [31:0]                         mem [MEM_DEPTH];
	logic [31:0]                         tex_rdata_s1;
	logic                                valid_s1;
	logic [11:0]                         row_s1;
	logic [11:0]                         col_s1;
	logic                                last_s1;
	logic                                halve_s1;

	logic                                pix_valid_q;
	rwtc_pkg::pix_t                      pix_q;

	logic                                accept;
	logic                                adv_s1;
	logic                                load_fire;
	logic                                col_fire;
	logic                                row_fire;
	logic                                mirror;
	logic [rwtc_pkg::TEX_BITS-1:0]       col_raw;
	logic [rwtc_pkg::TEX_BITS-1:0]       ty;
	logic [rwtc_pkg::ADDR_W-1:0]         wr_addr;
	logic [rwtc_pkg::ADDR_W-1:0]         rd_addr;
	logic signed [rwtc_pkg::OFF_W-1:0]   offset_d;
	logic signed [rwtc_pkg::STEP_W:0]    step_s;
	logic signed [rwtc_pkg::POS_W-1:0]   mul_res;
	logic [31:0]                         color_d;
	rwtc_pkg::div_stat_t                 div_stat;
	logic [rwtc_pkg::STEP_W-1:0]         div_quo;

	assign adv_s1    = !pix_valid_q || pix_ready;
	assign cmd_ready = (state_q == ST_IDLE) && (!valid_s1 || adv_s1);
	assign accept    = cmd_valid && cmd_ready;
	assign load_fire = accept && (cmd.kind == rwtc_pkg::KIND_LOAD)
		&& (32'(cmd.texel_addr) < rwtc_pkg::TEX_AREA);
	assign col_fire  = accept && (cmd.kind == rwtc_pkg::KIND_COLUMN);
	assign row_fire  = accept && (cmd.kind == rwtc_pkg::KIND_ROW) && (cur_row_q < end_row_q);

	assign mirror  = cmd.side ? cmd.dir_y_pos : cmd.dir_x_neg;
	assign col_raw = rwtc_pkg::TEX_BITS'(cmd.wall_x >> (16 - rwtc_pkg::TEX_BITS));

	assign offset_d = $signed({4'b0, cmd.first_row})
		- $signed({4'b0, sh_q[rwtc_pkg::SH_W-1:1]})
		+ $signed({2'b0, cmd.line_height[rwtc_pkg::LH_W-1:1]});

	assign step_s  = $signed({1'b0, div_quo});
	assign mul_res = offset_q * step_s;

	// truncate toward zero: bump negative values that carry a fraction
	assign ty = pos_q[16 +: rwtc_pkg::TEX_BITS]
		+ rwtc_pkg::TEX_BITS'(pos_q[rwtc_pkg::POS_W-1] && (pos_q[15:0] != '0));

	assign wr_addr = {cmd.tex_id, rwtc_pkg::LOC_W'(cmd.texel_addr)};
	assign rd_addr = {face_q, ty, tex_col_q};

	rwtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (col_fire),
		.divisor  (cmd.line_height),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (load_fire) begin
			mem[wr_addr] <= cmd.texel_value;
		end
		if (row_fire) begin
			tex_rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sh_q      <= rwtc_pkg::SH_RESET;
			face_q    <= rwtc_pkg::FACE_NORTH;
			tex_col_q <= '0;
			step_q    <= '0;
			pos_q     <= '0;
			cur_row_q <= '0;
			end_row_q <= '0;
			col_q     <= '0;
			offset_q  <= '0;
		end else begin
			if (cfg_we) begin
				sh_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (col_fire) begin
						if (cmd.side) begin
							face_q <= cmd.dir_y_pos ? rwtc_pkg::FACE_SOUTH
								: rwtc_pkg::FACE_NORTH;
						end else begin
							face_q <= cmd.dir_x_neg ? rwtc_pkg::FACE_WEST
								: rwtc_pkg::FACE_EAST;
						end
						tex_col_q <= mirror ? ~col_raw : col_raw;
						offset_q  <= offset_d;
						cur_row_q <= {1'b0, cmd.first_row};
						end_row_q <= cmd.stop_row;
						col_q     <= cmd.column;
						state_q   <= ST_DIV;
					end else if (row_fire) begin
						pos_q     <= pos_q + rwtc_pkg::POS_W'(step_q);
						cur_row_q <= cur_row_q + 13'd1;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q  <= div_quo;
					pos_q   <= mul_res;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (row_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				pix_valid_q <= valid_s1;
			end
		end
	end

	// hold the row metadata alongside the RAM read
	always_ff @(posedge clk) begin
		if (row_fire) begin
			row_s1   <= cur_row_q[11:0];
			col_s1   <= col_q;
			last_s1  <= (cur_row_q + 13'd1 == end_row_q);
			halve_s1 <= (face_q == rwtc_pkg::FACE_NORTH) || (face_q == rwtc_pkg::FACE_EAST);
		end
	end

	assign color_d = halve_s1 ? {24'b0, tex_rdata_s1[8:1]} : tex_rdata_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			pix_q.row          <= row_s1;
			pix_q.pixel_column <= col_s1;
			pix_q.color        <= color_d;
			pix_q.write        <= (color_d != '0) && !color_d[31];
			pix_q.last         <= last_s1;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(tex_rdata_s1))
		else $error("texel read data lost while output stalled");

	a_row_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> $stable(cur_row_q) && $stable(end_row_q))
		else $error("row counters moved during column setup");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !div_stat.done |-> div_stat.busy)
		else $error("divide state without a running divider");
`endif

endmodule
